/* rtl/core/pfb_pkg.sv */
// Shared types, panel geometry and the 5x7 font table of the page frame buffer drawer.
// Used by the controller, the datapath and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package pfb_pkg;

   // Panel geometry; the frame store holds one byte per column per 8-row page.
   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 64;
   localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
   localparam int ADDR_W       = $clog2(STORE_BYTES);
   localparam int PAGE_W       = 5;
   localparam int IDX_W        = 14;

   // Font geometry and the character range held in the font table.
   localparam int GLYPH_COLS    = 5;
   localparam int GLYPH_ROWS    = 7;
   localparam int GLYPH_FIRST   = 32;
   localparam int GLYPH_LAST    = 90;
   localparam int LOWER_FIRST   = 97;
   localparam int LOWER_LAST    = 122;
   localparam int FALLBACK_CODE = 63;

   // Command codes carried in req_type.
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_CHAR  = 2'd1,
      OP_BAR   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic sweep_init;
      logic sweep_step;
      logic mem_rd;
      logic rd_sel_index;
      logic rmw_wr;
      logic result_load;
   } pfb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   empty;
      logic   sweep_last;
      logic   rmw_last;
   } pfb_stat_type;

   // Maps a character code to its font table row. Lowercase folds to uppercase and
   // anything without a glyph of its own draws the question mark.
   function automatic logic [5:0] pfb_fold(input logic [7:0] code);
      logic [7:0] row;
      if (code >= 8'(GLYPH_FIRST) && code <= 8'(GLYPH_LAST)) begin
         row = code - 8'(GLYPH_FIRST);
      end else if (code >= 8'(LOWER_FIRST) && code <= 8'(LOWER_LAST)) begin
         row = code - 8'(LOWER_FIRST) + 8'(GLYPH_LAST - 25 - GLYPH_FIRST);
      end else begin
         row = 8'(FALLBACK_CODE - GLYPH_FIRST);
      end
      return row[5:0];
   endfunction

   // Font table. Columns read left to right from the most significant byte,
   // and bit 0 of each column is the top row.
   function automatic logic [39:0] pfb_glyph(input logic [5:0] row);
      logic [39:0] bits;
      case (row)
         6'd0:  bits = 40'h00_00_00_00_00;
         6'd1:  bits = 40'h00_00_5F_00_00;
         6'd2:  bits = 40'h00_07_00_07_00;
         6'd3:  bits = 40'h14_7F_14_7F_14;
         6'd4:  bits = 40'h24_2A_7F_2A_12;
         6'd5:  bits = 40'h23_13_08_64_62;
         6'd6:  bits = 40'h36_49_55_22_50;
         6'd7:  bits = 40'h00_05_03_00_00;
         6'd8:  bits = 40'h00_1C_22_41_00;
         6'd9:  bits = 40'h00_41_22_1C_00;
         6'd10: bits = 40'h08_2A_1C_2A_08;
         6'd11: bits = 40'h08_08_3E_08_08;
         6'd12: bits = 40'h00_50_30_00_00;
         6'd13: bits = 40'h08_08_08_08_08;
         6'd14: bits = 40'h00_60_60_00_00;
         6'd15: bits = 40'h20_10_08_04_02;
         6'd16: bits = 40'h3E_51_49_45_3E;
         6'd17: bits = 40'h00_42_7F_40_00;
         6'd18: bits = 40'h42_61_51_49_46;
         6'd19: bits = 40'h21_41_45_4B_31;
         6'd20: bits = 40'h18_14_12_7F_10;
         6'd21: bits = 40'h27_45_45_45_39;
         6'd22: bits = 40'h3C_4A_49_49_30;
         6'd23: bits = 40'h01_71_09_05_03;
         6'd24: bits = 40'h36_49_49_49_36;
         6'd25: bits = 40'h06_49_49_29_1E;
         6'd26: bits = 40'h00_36_36_00_00;
         6'd27: bits = 40'h00_56_36_00_00;
         6'd28: bits = 40'h00_08_14_22_41;
         6'd29: bits = 40'h14_14_14_14_14;
         6'd30: bits = 40'h41_22_14_08_00;
         6'd31: bits = 40'h02_01_51_09_06;
         6'd32: bits = 40'h32_49_79_41_3E;
         6'd33: bits = 40'h7E_11_11_11_7E;
         6'd34: bits = 40'h7F_49_49_49_36;
         6'd35: bits = 40'h3E_41_41_41_22;
         6'd36: bits = 40'h7F_41_41_22_1C;
         6'd37: bits = 40'h7F_49_49_49_41;
         6'd38: bits = 40'h7F_09_09_01_01;
         6'd39: bits = 40'h3E_41_41_51_32;
         6'd40: bits = 40'h7F_08_08_08_7F;
         6'd41: bits = 40'h00_41_7F_41_00;
         6'd42: bits = 40'h20_40_41_3F_01;
         6'd43: bits = 40'h7F_08_14_22_41;
         6'd44: bits = 40'h7F_40_40_40_40;
         6'd45: bits = 40'h7F_02_04_02_7F;
         6'd46: bits = 40'h7F_04_08_10_7F;
         6'd47: bits = 40'h3E_41_41_41_3E;
         6'd48: bits = 40'h7F_09_09_09_06;
         6'd49: bits = 40'h3E_41_51_21_5E;
         6'd50: bits = 40'h7F_09_19_29_46;
         6'd51: bits = 40'h46_49_49_49_31;
         6'd52: bits = 40'h01_01_7F_01_01;
         6'd53: bits = 40'h3F_40_40_40_3F;
         6'd54: bits = 40'h1F_20_40_20_1F;
         6'd55: bits = 40'h7F_20_18_20_7F;
         6'd56: bits = 40'h63_14_08_14_63;
         6'd57: bits = 40'h03_04_78_04_03;
         6'd58: bits = 40'h61_51_49_45_43;
         default: bits = 40'h00_00_00_00_00;
      endcase
      return bits;
   endfunction

endpackage

/* rtl/core/pfb_req_if.sv */
// Command channel of the page frame buffer drawer: valid, ready and one command.
// Depends on nothing.
`timescale 1ns / 1ps

interface pfb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] pos_x;
   logic [6:0] pos_y;
   logic [7:0] char_code;
   logic [7:0] bar_width;
   logic [6:0] bar_height;
   logic [7:0] bar_filled;
   logic [9:0] read_index;

   modport source (
      output valid, req_type, pos_x, pos_y, char_code,
             bar_width, bar_height, bar_filled, read_index,
      input  ready
   );

   modport sink (
      input  valid, req_type, pos_x, pos_y, char_code,
             bar_width, bar_height, bar_filled, read_index,
      output ready
   );
endinterface

/* rtl/core/pfb_rsp_if.sv */
// Result channel of the page frame buffer drawer: valid, ready and one result byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface pfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (
      output valid, read_data,
      input  ready
   );

   modport sink (
      input  valid, read_data,
      output ready
   );
endinterface

/* rtl/core/pfb_datapath.sv */
// Datapath of the page frame buffer drawer: frame store memory, command registers,
// column and page counters, pixel mask and merge logic, and the result register.
// Depends on pfb_pkg.
`timescale 1ns / 1ps

module pfb_datapath import pfb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  pfb_cmd_type  cmd,
   output pfb_stat_type stat,
   input  logic [1:0]   req_type,
   input  logic [7:0]   pos_x,
   input  logic [6:0]   pos_y,
   input  logic [7:0]   char_code,
   input  logic [7:0]   bar_width,
   input  logic [6:0]   bar_height,
   input  logic [7:0]   bar_filled,
   input  logic [9:0]   read_index,
   output logic [7:0]   read_data
);

   // Frame store and its registered read port.
   logic [7:0] store_mem [STORE_BYTES];
   logic [7:0] mem_q_ff;

   // Command registers.
   op_type            op_ff, op_in;
   logic              empty_ff, empty_in;
   logic [7:0]        x0_ff, x0_in;
   logic [6:0]        lo_ff, lo_in;
   logic [7:0]        hi_ff, hi_in;
   logic [7:0]        w_ff, w_in;
   logic [7:0]        filled_ff, filled_in;
   logic [39:0]       glyph_ff, glyph_in;
   logic [9:0]        ridx_ff, ridx_in;
   logic [PAGE_W-1:0] first_ff, first_in;
   logic [PAGE_W-1:0] last_ff, last_in;

   // Iteration counters.
   logic [7:0]        col_ff, col_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [7:0]        result_ff, result_in;

   // Load-time decode.
   logic              req_is_char;
   logic [7:0]        hi_load;
   logic [7:0]        hi_less;
   logic [PAGE_W-1:0] last_raw;
   logic [7:0]        w_load;

   // Per-byte drawing logic.
   logic [8:0]        x_col;
   logic [7:0]        row_base;
   logic [2:0]        gsel;
   logic [7:0]        gcol;
   logic              col_on;
   logic [7:0]        pix_mask;
   logic [7:0]        pix_data;
   logic [7:0]        merged;
   logic [ADDR_W-1:0] draw_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              col_last;
   logic              page_last;
   logic              ridx_ok;

   // Decode a command as it is accepted.
   always_comb begin
      req_is_char = (req_type == OP_CHAR);
      hi_load     = 8'(pos_y) + (req_is_char ? 8'(GLYPH_ROWS) : 8'(bar_height));
      hi_less     = hi_load - 8'd1;
      last_raw    = PAGE_W'(hi_less[7:3]);
      w_load      = req_is_char ? 8'(GLYPH_COLS) : bar_width;
   end

   // Command register next values.
   always_comb begin
      op_in     = op_ff;
      empty_in  = empty_ff;
      x0_in     = x0_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      w_in      = w_ff;
      filled_in = filled_ff;
      glyph_in  = glyph_ff;
      ridx_in   = ridx_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      if (cmd.load) begin
         op_in     = op_type'(req_type);
         empty_in  = (w_load == 8'd0) || (hi_load == 8'(pos_y)) ||
                     (PAGE_W'(pos_y[6:3]) >= PAGE_W'(PAGE_COUNT)) ||
                     ({1'b0, pos_x} >= 9'(PANEL_WIDTH));
         x0_in     = pos_x;
         lo_in     = pos_y;
         hi_in     = hi_load;
         w_in      = w_load;
         filled_in = bar_filled;
         glyph_in  = pfb_glyph(pfb_fold(char_code));
         ridx_in   = read_index;
         first_in  = PAGE_W'(pos_y[6:3]);
         last_in   = (last_raw > PAGE_W'(PAGE_COUNT - 1)) ? PAGE_W'(PAGE_COUNT - 1)
                                                          : last_raw;
      end
   end

   // Pixel mask and data for the byte at the current column and page.
   always_comb begin
      logic [7:0] row;
      logic [7:0] grow;
      x_col    = {1'b0, x0_ff} + {1'b0, col_ff};
      row_base = {page_ff[4:0], 3'b000};
      gsel     = 3'd4 - col_ff[2:0];
      gcol     = glyph_ff[{gsel, 3'b000} +: 8];
      col_on   = (col_ff < filled_ff);
      for (int b = 0; b < 8; b++) begin
         row         = row_base | 8'(b);
         grow        = row - {1'b0, lo_ff};
         pix_mask[b] = (row >= {1'b0, lo_ff}) && (row < hi_ff) &&
                       (row < 8'(PANEL_HEIGHT));
         pix_data[b] = (op_ff == OP_CHAR) ? gcol[grow[2:0]] : col_on;
      end
      merged    = (mem_q_ff & ~pix_mask) | (pix_data & pix_mask);
      draw_addr = ADDR_W'(IDX_W'(x_col) + IDX_W'(page_ff) * IDX_W'(PANEL_WIDTH));
      rd_addr   = cmd.rd_sel_index ? ADDR_W'(ridx_ff) : draw_addr;
      col_last  = (col_ff == w_ff - 8'd1) || ({1'b0, x_col} >= 10'(PANEL_WIDTH - 1));
      page_last = (page_ff == last_ff);
      ridx_ok   = (IDX_W'(ridx_ff) < IDX_W'(STORE_BYTES));
   end

   // Counter and result next values.
   always_comb begin
      col_in    = col_ff;
      page_in   = page_ff;
      sweep_in  = sweep_ff;
      result_in = result_ff;
      if (cmd.load) begin
         col_in  = 8'd0;
         page_in = PAGE_W'(pos_y[6:3]);
      end else if (cmd.rmw_wr) begin
         if (page_last) begin
            page_in = first_ff;
            col_in  = col_ff + 8'd1;
         end else begin
            page_in = page_ff + PAGE_W'(1);
         end
      end
      if (cmd.sweep_init) begin
         sweep_in = '0;
      end else if (cmd.sweep_step) begin
         sweep_in = sweep_ff + ADDR_W'(1);
      end
      if (cmd.result_load) begin
         result_in = (op_ff == OP_READ && ridx_ok) ? mem_q_ff : 8'd0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      empty_ff  <= empty_in;
      x0_ff     <= x0_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      w_ff      <= w_in;
      filled_ff <= filled_in;
      glyph_ff  <= glyph_in;
      ridx_ff   <= ridx_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      col_ff    <= col_in;
      page_ff   <= page_in;
      result_ff <= result_in;
   end

   // The sweep counter starts the clearing pass right out of reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   // Frame store: one write port shared by clearing and drawing, one registered read.
   always_ff @(posedge clock) begin
      if (cmd.sweep_step) begin
         store_mem[sweep_ff] <= 8'd0;
      end else if (cmd.rmw_wr) begin
         store_mem[draw_addr] <= merged;
      end
      if (cmd.mem_rd) begin
         mem_q_ff <= store_mem[rd_addr];
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.op         = op_ff;
      stat.empty      = empty_ff;
      stat.sweep_last = (sweep_ff == ADDR_W'(STORE_BYTES - 1));
      stat.rmw_last   = page_last && col_last;
   end

   assign read_data = result_ff;

endmodule

/* rtl/core/pfb_ctrl.sv */
// Controller of the page frame buffer drawer: sequences clearing sweeps, byte
// read-modify-write passes and store reads, and owns the result valid flag.
// Depends on pfb_pkg.
`timescale 1ns / 1ps

module pfb_ctrl import pfb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output pfb_cmd_type  cmd,
   input  pfb_stat_type stat
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_SWEEP,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Decode commands and the next state.
   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.op)
               OP_CLEAR: begin
                  cmd.sweep_init = 1'b1;
                  state_in       = ST_SWEEP;
               end
               OP_READ: begin
                  cmd.mem_rd       = 1'b1;
                  cmd.rd_sel_index = 1'b1;
                  state_in         = ST_DONE;
               end
               default: begin
                  state_in = stat.empty ? ST_DONE : ST_RMW_RD;
               end
            endcase
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_RMW_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            cmd.rmw_wr = 1'b1;
            state_in   = stat.rmw_last ? ST_DONE : ST_RMW_RD;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/page_framebuffer_text_and_bar_drawer_core.sv */
// Top level of the page frame buffer drawer: joins the controller and the datapath
// to the command and result channels.
// Depends on pfb_pkg, pfb_req_if, pfb_rsp_if, pfb_ctrl and pfb_datapath.
//
//   Channel   Direction  Contents
//   req_bus   in         req_type, pos_x, pos_y, char_code, bar_width, bar_height,
//                        bar_filled, read_index
//   rsp_bus   out        read_data (one transaction for every command)
//
// One command is in flight at a time; the frame store has one write and one read port.
// Clear zeroes all STORE_BYTES store bytes, one store byte per cycle. Char and bar do
// one read and one write for every touched store byte, and read fetches one store byte.
// After reset the store is zeroed by a clearing pass with req_bus not ready.
// A finished result waits in the output register while the next command is accepted.
`timescale 1ns / 1ps

module page_framebuffer_text_and_bar_drawer_core import pfb_pkg::*; (
   input logic   clock,
   input logic   reset,
   pfb_req_if.sink   req_bus,
   pfb_rsp_if.source rsp_bus
);

   pfb_cmd_type  cmd;
   pfb_stat_type stat;

   // Sequencing of each command.
   pfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Frame store and drawing logic.
   pfb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_type   (req_bus.req_type),
      .pos_x      (req_bus.pos_x),
      .pos_y      (req_bus.pos_y),
      .char_code  (req_bus.char_code),
      .bar_width  (req_bus.bar_width),
      .bar_height (req_bus.bar_height),
      .bar_filled (req_bus.bar_filled),
      .read_index (req_bus.read_index),
      .read_data  (rsp_bus.read_data)
   );

endmodule
